@@ design/isolated_hit_filter_1d_defines.svh @@
// ----------------------------------------------------------------------------
// Isolated hit filter assertion macros
// Clocked assertion helpers used by the scan sequencer.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_HIT_FILTER_1D_DEFINES_SVH
`define ISOLATED_HIT_FILTER_1D_DEFINES_SVH

// property holds at every clock edge out of reset
`define IHF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression is never true out of reset
`define IHF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ design/ihf_pkg.sv @@
// ----------------------------------------------------------------------------
// Isolated hit filter package
// Payload types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihf_pkg;

  localparam int COORD_W    = 12;
  localparam int TAG_W      = 16;
  localparam int DIST_W     = 12;
  localparam int MINN_W     = 7;
  localparam int NCNT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NEIGHBOURS = 2'd1;

  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST   = 12'd1;
  localparam logic [MINN_W-1:0] MIN_NEIGHBOURS_RST = 7'd1;

  typedef struct packed {
    logic [COORD_W-1:0] hit_coord;
    logic [TAG_W-1:0]   hit_tag;
    logic               last_hit;
  } in_t;

  typedef struct packed {
    logic [TAG_W-1:0]   out_tag;
    logic [COORD_W-1:0] out_coord;
    logic               keep;
    logic [NCNT_W-1:0]  neighbour_count;
    logic               overflow;
    logic               last_result;
  } out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_CAP_I,
    ST_SCAN,
    ST_EMIT
  } scan_state_t;

endpackage

@@ design/isolated_hit_filter_1d.sv @@
// ----------------------------------------------------------------------------
// Isolated hit filter, one dimension
// Flags (keep) hits that have enough neighbours within a configured distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : hit requests (coord, tag, last_hit). One request per cycle is
//           taken while the set loads; in_stall is high from the last hit of
//           a set until its final result sits in the output register.
//   out_* : one result request per stored hit, in load order, last_result on
//           the final one. Hits past MAX_HITS are dropped and flag overflow.
//   cfg_* : register writes (index 0 max_distance, 1 min_neighbours),
//           always ready; write only while no set is in flight.
// Sequence: each stored hit is read (ST_RD_I), captured (ST_CAP_I), then
//   scored by sweeping the single coordinate memory read port one entry per
//   cycle over the whole set (ST_SCAN), and emitted (ST_EMIT).
// Reset: synchronous rst_n empties the set and loads both registers with 1.
//   Memory contents are not cleared; only written entries are read.
// A stalled receiver holds the output register and holds the sequencer in ST_EMIT.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isolated_hit_filter_1d #(
  parameter int MAX_HITS   = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  ihf_pkg::in_t                   in_data,
  output logic                           in_stall,
  output logic                           out_valid,
  output ihf_pkg::out_t                  out_data,
  input  logic                           out_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ihf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = (MAX_HITS > 2) ? $clog2(MAX_HITS) : 1;
  localparam int HW = $clog2(MAX_HITS + 1);

  logic [ihf_pkg::DIST_W-1:0] max_dist_r;
  logic [ihf_pkg::MINN_W-1:0] min_nb_r;

  logic                      mem_we;
  logic [IW-1:0]             mem_waddr, mem_raddr_c, mem_raddr_t;
  logic [COORD_BITS-1:0]     mem_wcoord, mem_rcoord;
  logic [ihf_pkg::TAG_W-1:0] mem_wtag, mem_rtag;

  logic          slot_free, emit;
  ihf_pkg::out_t res;
  logic          out_valid_r;
  ihf_pkg::out_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= ihf_pkg::MAX_DISTANCE_RST;
      min_nb_r   <= ihf_pkg::MIN_NEIGHBOURS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ihf_pkg::REG_MAX_DISTANCE:   max_dist_r <= cfg_data[ihf_pkg::DIST_W-1:0];
        ihf_pkg::REG_MIN_NEIGHBOURS: min_nb_r   <= cfg_data[ihf_pkg::MINN_W-1:0];
        default: ;
      endcase
    end
  end

  ihf_store #(
    .DEPTH (MAX_HITS),
    .CW    (COORD_BITS),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wcoord  (mem_wcoord),
    .wtag    (mem_wtag),
    .raddr_c (mem_raddr_c),
    .raddr_t (mem_raddr_t),
    .rcoord  (mem_rcoord),
    .rtag    (mem_rtag)
  );

  ihf_scan #(
    .MAX_HITS   (MAX_HITS),
    .COORD_BITS (COORD_BITS),
    .IW         (IW),
    .HW         (HW)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_stall       (in_stall),
    .max_distance   (max_dist_r),
    .min_neighbours (min_nb_r),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wcoord     (mem_wcoord),
    .mem_wtag       (mem_wtag),
    .mem_raddr_c    (mem_raddr_c),
    .mem_raddr_t    (mem_raddr_t),
    .mem_rcoord     (mem_rcoord),
    .mem_rtag       (mem_rtag),
    .slot_free      (slot_free),
    .emit           (emit),
    .res            (res)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/ihf_store.sv @@
// ----------------------------------------------------------------------------
// Isolated hit filter hit store
// Coordinate and tag memories, one write port, registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihf_store #(
  parameter int DEPTH = 64,
  parameter int CW    = 12,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [CW-1:0]           wcoord,
  input  logic [ihf_pkg::TAG_W-1:0] wtag,
  input  logic [AW-1:0]           raddr_c,
  input  logic [AW-1:0]           raddr_t,
  output logic [CW-1:0]           rcoord,
  output logic [ihf_pkg::TAG_W-1:0] rtag
);

  logic [CW-1:0]             coord_mem [DEPTH];
  logic [ihf_pkg::TAG_W-1:0] tag_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      coord_mem[waddr] <= wcoord;
      tag_mem[waddr]   <= wtag;
    end
  end

  always_ff @(posedge clk) begin
    rcoord <= coord_mem[raddr_c];
    rtag   <= tag_mem[raddr_t];
  end

endmodule

@@ design/ihf_scan.sv @@
// ----------------------------------------------------------------------------
// Isolated hit filter scan sequencer
// Loads hits into the store, then counts neighbours of each hit by sweeping
// the coordinate memory one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "isolated_hit_filter_1d_defines.svh"

module ihf_scan #(
  parameter int MAX_HITS   = 64,
  parameter int COORD_BITS = 12,
  parameter int IW         = 6,
  parameter int HW         = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  ihf_pkg::in_t               in_data,
  output logic                       in_stall,
  input  logic [ihf_pkg::DIST_W-1:0] max_distance,
  input  logic [ihf_pkg::MINN_W-1:0] min_neighbours,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output logic [COORD_BITS-1:0]      mem_wcoord,
  output logic [ihf_pkg::TAG_W-1:0]  mem_wtag,
  output logic [IW-1:0]              mem_raddr_c,
  output logic [IW-1:0]              mem_raddr_t,
  input  logic [COORD_BITS-1:0]      mem_rcoord,
  input  logic [ihf_pkg::TAG_W-1:0]  mem_rtag,
  input  logic                       slot_free,
  output logic                       emit,
  output ihf_pkg::out_t              res
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = (CW > ihf_pkg::COORD_W) ? CW : ihf_pkg::COORD_W;
  localparam int CNTW = (MAX_HITS > 2) ? $clog2(MAX_HITS) : 1;

  ihf_pkg::scan_state_t state_r, state_nxt;

  logic [HW-1:0]   hc_r, hc_nxt;
  logic            ovf_r, ovf_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [IW-1:0]   j_r, j_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   ci_r, ci_nxt;

  logic [DW-1:0]   in_ext, ci_ext, cj_ext, diff;
  logic            full, j_last, i_last, in_reach, hit_j;

  assign in_ext   = DW'(in_data.hit_coord);
  assign ci_ext   = DW'(ci_r);
  assign cj_ext   = DW'(mem_rcoord);
  assign diff     = (ci_ext >= cj_ext) ? (ci_ext - cj_ext) : (cj_ext - ci_ext);
  assign in_reach = diff <= DW'(max_distance);
  assign hit_j    = (j_r != i_r) && in_reach;

  assign full   = hc_r == HW'(MAX_HITS);
  assign j_last = HW'(j_r) == (hc_r - HW'(1));
  assign i_last = HW'(i_r) == (hc_r - HW'(1));

  assign in_stall    = state_r != ihf_pkg::ST_LOAD;
  assign mem_waddr   = hc_r[IW-1:0];
  assign mem_wcoord  = in_ext[CW-1:0];
  assign mem_wtag    = in_data.hit_tag;
  assign mem_raddr_t = i_r;

  always_comb begin
    res.out_tag         = mem_rtag;
    res.out_coord       = ci_ext[ihf_pkg::COORD_W-1:0];
    res.keep            = ihf_pkg::MINN_W'(cnt_r) >= min_neighbours;
    res.neighbour_count = ihf_pkg::NCNT_W'(cnt_r);
    res.overflow        = ovf_r;
    res.last_result     = i_last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ihf_pkg::ST_LOAD: begin
        if (in_valid && in_data.last_hit) state_nxt = ihf_pkg::ST_RD_I;
      end
      ihf_pkg::ST_RD_I:  state_nxt = ihf_pkg::ST_CAP_I;
      ihf_pkg::ST_CAP_I: state_nxt = ihf_pkg::ST_SCAN;
      ihf_pkg::ST_SCAN: begin
        if (j_last) state_nxt = ihf_pkg::ST_EMIT;
      end
      ihf_pkg::ST_EMIT: begin
        if (slot_free) state_nxt = i_last ? ihf_pkg::ST_LOAD : ihf_pkg::ST_RD_I;
      end
      default: state_nxt = ihf_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    hc_nxt      = hc_r;
    ovf_nxt     = ovf_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    ci_nxt      = ci_r;
    mem_we      = 1'b0;
    mem_raddr_c = i_r;
    emit        = 1'b0;
    case (state_r)
      ihf_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we = 1'b1;
            hc_nxt = hc_r + HW'(1);
          end
        end
      end
      ihf_pkg::ST_RD_I: begin
        mem_raddr_c = i_r;
      end
      ihf_pkg::ST_CAP_I: begin
        ci_nxt      = mem_rcoord;
        cnt_nxt     = '0;
        j_nxt       = '0;
        mem_raddr_c = '0;
      end
      ihf_pkg::ST_SCAN: begin
        if (hit_j) cnt_nxt = cnt_r + CNTW'(1);
        if (!j_last) begin
          j_nxt       = j_r + IW'(1);
          mem_raddr_c = j_r + IW'(1);
        end
      end
      ihf_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (i_last) begin
            i_nxt   = '0;
            hc_nxt  = '0;
            ovf_nxt = 1'b0;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      default: begin
        mem_raddr_c = i_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ihf_pkg::ST_LOAD;
      hc_r    <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hc_r    <= hc_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ci_r <= ci_nxt;
  end

  `IHF_ASSERT(a_hc_bound, hc_r <= HW'(MAX_HITS), "hit count above capacity")
  `IHF_ASSERT_NEVER(a_scan_empty, (state_r != ihf_pkg::ST_LOAD) && (hc_r == '0), "scan of empty set")
  `IHF_ASSERT(a_cnt_bound, (state_r == ihf_pkg::ST_EMIT) |-> (HW'(cnt_r) < hc_r), "count too large")
  `IHF_ASSERT(a_set_clear, (emit && i_last) |=> ((hc_r == '0) && !ovf_r && (i_r == '0)), "set not cleared")
  `IHF_ASSERT_NEVER(a_wr_outside_load, mem_we && (state_r != ihf_pkg::ST_LOAD), "store write during scan")

endmodule
